// ----- hdl/ssf_pkg.sv -----
// ----------------------------------------------------------------------------
// ssf_pkg - shared types and constants for the strand smoothing filter
// Coefficient record, per-item filter mode and the Q1.16 weight constants.
// ----------------------------------------------------------------------------
package ssf_pkg;

	// smoothing weight is unsigned Q1.16, 1.0 = 65536
	localparam int BETA_FRAC = 16;
	localparam int BETA_W    = 17;

	localparam logic [BETA_W-1:0] BETA_ONE   = 17'd65536;
	localparam logic [BETA_W-1:0] BETA_ROUND = 17'd32768;

	// k1 = 2(1-b), k2 = (1-b)^2, k3 = b^2, all Q.16
	typedef struct packed {
		logic [BETA_W:0]   k1;
		logic [BETA_W-1:0] k2;
		logic [BETA_W-1:0] k3;
	} ssf_coef_t;

	// coefficients for the reset weight of one half
	localparam ssf_coef_t COEF_RESET = '{k1: 18'd65536, k2: 17'd16384, k3: 17'd16384};

	// what an item does with the filter history
	typedef enum logic [1:0] {
		MODE_FIRST,   // first point of a strand: pass through
		MODE_SECOND,  // second point: raw difference seeds both taps
		MODE_STEADY   // recursive filter
	} ssf_mode_t;

endpackage

// ----- hdl/ssf_lane.sv -----
// ----------------------------------------------------------------------------
// ssf_lane - one coordinate of the strand smoothing filter
// Saturating difference, second-order recursion, saturating accumulate.
// ----------------------------------------------------------------------------
module ssf_lane
	import ssf_pkg::*;
#(
	parameter int COORD_WIDTH = 32
) (
	input  ssf_mode_t                      mode,
	input  ssf_coef_t                      coef,
	input  logic signed [COORD_WIDTH-1:0] vec,
	input  logic signed [COORD_WIDTH-1:0] prev_vec,
	input  logic signed [COORD_WIDTH-1:0] diff_older,
	input  logic signed [COORD_WIDTH-1:0] diff_oldest,
	input  logic signed [COORD_WIDTH-1:0] prev_smooth,
	output logic signed [COORD_WIDTH-1:0] smooth,
	output logic signed [COORD_WIDTH-1:0] older_nxt,
	output logic signed [COORD_WIDTH-1:0] oldest_nxt,
	output logic                           sat
);

	localparam int W     = COORD_WIDTH;
	localparam int PRD_W = W + 19;
	localparam int ACC_W = W + 19;
	localparam int Q_W   = ACC_W - BETA_FRAC;

	localparam logic signed [W-1:0]     C_MAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0]     C_MIN = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [ACC_W-1:0] RND   = ACC_W'(BETA_ROUND);

	logic signed [W:0]       delta_w;
	logic signed [W-1:0]     delta;
	logic                    delta_sat;
	logic signed [PRD_W-1:0] prod1, prod2, prod3;
	logic signed [ACC_W-1:0] acc;
	logic signed [Q_W-1:0]   q;
	logic signed [W-1:0]     filt;
	logic                    filt_sat;
	logic signed [W-1:0]     d_new;
	logic signed [W:0]       sum_w;
	logic signed [W-1:0]     sum;
	logic                    sum_sat;

	// p(i+1) - p(i), one guard bit
	assign delta_w   = {vec[W-1], vec} - {prev_vec[W-1], prev_vec};
	assign delta_sat = delta_w[W] != delta_w[W-1];
	assign delta     = delta_sat ? (delta_w[W] ? C_MIN : C_MAX) : delta_w[W-1:0];

	assign prod1 = diff_older  * $signed({1'b0, coef.k1});
	assign prod2 = diff_oldest * $signed({2'b00, coef.k2});
	assign prod3 = delta       * $signed({2'b00, coef.k3});

	// exact sum, then round to nearest (ties up) back to Q.16
	assign acc = ACC_W'(prod1) - ACC_W'(prod2) + ACC_W'(prod3) + RND;
	assign q   = Q_W'(acc >>> BETA_FRAC);

	assign filt_sat = !((&q[Q_W-1:W-1]) || !(|q[Q_W-1:W-1]));
	assign filt     = filt_sat ? (q[Q_W-1] ? C_MIN : C_MAX) : q[W-1:0];

	assign d_new = (mode == MODE_SECOND) ? delta : filt;

	assign sum_w   = {prev_smooth[W-1], prev_smooth} + {d_new[W-1], d_new};
	assign sum_sat = sum_w[W] != sum_w[W-1];
	assign sum     = sum_sat ? (sum_w[W] ? C_MIN : C_MAX) : sum_w[W-1:0];

	always_comb begin
		case (mode)
			MODE_SECOND: begin
				smooth     = sum;
				older_nxt  = delta;
				oldest_nxt = delta;
				sat        = delta_sat | sum_sat;
			end
			MODE_STEADY: begin
				smooth     = sum;
				older_nxt  = filt;
				oldest_nxt = diff_older;
				sat        = delta_sat | filt_sat | sum_sat;
			end
			default: begin
				smooth     = vec;
				older_nxt  = '0;
				oldest_nxt = '0;
				sat        = 1'b0;
			end
		endcase
	end

endmodule

// ----- hdl/strand_smoothing_filter.sv -----
// ----------------------------------------------------------------------------
// strand_smoothing_filter - second-order recursive smoothing of strand vectors
// One 3D vector in, one smoothed vector out, one beat per clock unless the master side stalls.
// ----------------------------------------------------------------------------
// Usage: stream the vectors of a strand on the slave side, tuser[0] high on the
// first one. That beat comes back unchanged; the second returns s0 + (p1 - p0),
// and every later beat returns s(i) + d(i) with the recursive difference
// d(i) = 2(1-b)d(i-1) - (1-b)^2 d(i-2) + b^2 (p(i+1) - p(i)). A beat sent with
// no strand start since reset is treated as a strand start. Any clipped
// difference, filter value or sum raises tuser[0] on the result. The block
// sustains one beat per clock while the master side is not stalled; an input
// beat waits in the input stage register, then moves into the result register
// that drives the master side. The filter history is updated on that same move,
// so the three lane multipliers, the accumulate and the clamp sit in a single
// register-to-register path from the input stage to the history and result
// registers. Write b (unsigned Q1.16, values above 1.0 act as 1.0) only while
// no beat is in flight; its coefficients are formed on the write.
// ----------------------------------------------------------------------------
module strand_smoothing_filter
	import ssf_pkg::*;
#(
	parameter  int COORD_WIDTH = 32,
	localparam int TDATA_W     = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
	input  logic               clk,
	input  logic               arst_n,

	// configuration: smoothing weight b
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [BETA_W-1:0]  cfg_data,    // beta_q16

	// input vectors
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,     // vec_x, vec_y, vec_z, zero pad
	input  logic [0:0]         s_tuser,     // strand_start

	// smoothed vectors
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,     // smooth_x, smooth_y, smooth_z, zero pad
	output logic [0:0]         m_tuser      // saturated
);

	localparam int W = COORD_WIDTH;

	// ---------------- coefficients, formed on a config write ----------------
	logic [BETA_W-1:0] beta_clip;
	logic [BETA_W-1:0] one_m_beta;
	logic [2*BETA_W-2:0] m_sq, b_sq;
	ssf_coef_t         coef_nxt;
	ssf_coef_t         coef_q;

	assign cfg_ready  = 1'b1;
	assign beta_clip  = (cfg_data > BETA_ONE) ? BETA_ONE : cfg_data;
	assign one_m_beta = BETA_ONE - beta_clip;
	// squares are at most 2^32, plus half an LSB still fits in 33 bits
	assign m_sq = one_m_beta * one_m_beta + (2*BETA_W-1)'(BETA_ROUND);
	assign b_sq = beta_clip * beta_clip + (2*BETA_W-1)'(BETA_ROUND);

	always_comb begin
		coef_nxt.k1 = {one_m_beta, 1'b0};
		coef_nxt.k2 = m_sq[BETA_FRAC +: BETA_W];
		coef_nxt.k3 = b_sq[BETA_FRAC +: BETA_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= COEF_RESET;
		end else if (cfg_valid && cfg_ready) begin
			coef_q <= coef_nxt;
		end
	end

	// ---------------- handshake ----------------
	// s1 holds the accepted beat; it moves on whenever the result register
	// is empty or being drained, so a waiting result still lets one more in.
	logic               valid_s1;
	logic               start_s1;
	logic signed [W-1:0] vec_s1 [3];
	logic               in_beat;
	logic               advance;

	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign in_beat  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_beat) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			start_s1 <= s_tuser[0];
			for (int j = 0; j < 3; j++) begin
				vec_s1[j] <= s_tdata[j*W +: W];
			end
		end
	end

	// ---------------- filter history ----------------
	logic [1:0]          count_q;   // points seen in this strand, sticks at 2
	logic signed [W-1:0] prev_vec_q    [3];
	logic signed [W-1:0] diff_older_q  [3];
	logic signed [W-1:0] diff_oldest_q [3];
	logic signed [W-1:0] prev_smooth_q [3];
	ssf_mode_t           mode;

	always_comb begin
		if (start_s1 || count_q == 2'd0) begin
			mode = MODE_FIRST;
		end else if (count_q == 2'd1) begin
			mode = MODE_SECOND;
		end else begin
			mode = MODE_STEADY;
		end
	end

	// ---------------- per-coordinate datapath ----------------
	logic signed [W-1:0] smooth     [3];
	logic signed [W-1:0] older_nxt  [3];
	logic signed [W-1:0] oldest_nxt [3];
	logic [2:0]          lane_sat;

	for (genvar g = 0; g < 3; g++) begin : g_lane
		ssf_lane #(
			.COORD_WIDTH(W)
		) u_lane (
			.mode        (mode),
			.coef        (coef_q),
			.vec         (vec_s1[g]),
			.prev_vec    (prev_vec_q[g]),
			.diff_older  (diff_older_q[g]),
			.diff_oldest (diff_oldest_q[g]),
			.prev_smooth (prev_smooth_q[g]),
			.smooth      (smooth[g]),
			.older_nxt   (older_nxt[g]),
			.oldest_nxt  (oldest_nxt[g]),
			.sat         (lane_sat[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
			for (int j = 0; j < 3; j++) begin
				prev_vec_q[j]    <= '0;
				diff_older_q[j]  <= '0;
				diff_oldest_q[j] <= '0;
				prev_smooth_q[j] <= '0;
			end
		end else if (advance) begin
			count_q <= (mode == MODE_FIRST) ? 2'd1 : 2'd2;
			for (int j = 0; j < 3; j++) begin
				prev_vec_q[j]    <= vec_s1[j];
				diff_older_q[j]  <= older_nxt[j];
				diff_oldest_q[j] <= oldest_nxt[j];
				prev_smooth_q[j] <= smooth[j];
			end
		end
	end

	// ---------------- result register ----------------
	logic                out_valid_q;
	logic signed [W-1:0] smooth_q [3];
	logic                sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			sat_q <= |lane_sat;
			for (int j = 0; j < 3; j++) begin
				smooth_q[j] <= smooth[j];
			end
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = TDATA_W'({smooth_q[2], smooth_q[1], smooth_q[0]});
	assign m_tuser[0] = sat_q;

endmodule

// ----- hdl/ssf_checker.sv -----
// ----------------------------------------------------------------------------
// ssf_checker - port-level checks for the strand smoothing filter
// Watches handshakes and strand-start pass-through; bound to the top level.
// ----------------------------------------------------------------------------
module ssf_checker #(
	parameter  int COORD_WIDTH = 32,
	localparam int TDATA_W     = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
	input logic               clk,
	input logic               arst_n,
	input logic               cfg_valid,
	input logic               cfg_ready,
	input logic               s_tvalid,
	input logic               s_tready,
	input logic [TDATA_W-1:0] s_tdata,
	input logic [0:0]         s_tuser,
	input logic               m_tvalid,
	input logic               m_tready,
	input logic [TDATA_W-1:0] m_tdata,
	input logic [0:0]         m_tuser
);

	localparam int VW = 3 * COORD_WIDTH;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// input side only backs up when a result is waiting
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled with no result waiting");

	// a new result must trace back to an accepted input beat
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("result without input beat");

	// strand start passes straight through, unflagged
	a_start_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser[0]) ##1 (!m_tvalid || m_tready)
		|=> m_tvalid && !m_tuser[0] && m_tdata[VW-1:0] == $past(s_tdata[VW-1:0], 2))
		else $error("strand start not passed through");

	// weight is only rewritten with no result waiting
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |-> !m_tvalid)
		else $error("weight written with a result in flight");

endmodule

bind strand_smoothing_filter ssf_checker #(.COORD_WIDTH(COORD_WIDTH)) u_ssf_checker (.*);

// ----- tb/strand_smoothing_filter_test.sv -----
// ----------------------------------------------------------------------------
// strand_smoothing_filter_test - self-checking bench for the strand smoother
// Drives strands of 3D vectors through the stream ports. A bit-exact model of
// the second-order smoother predicts every result beat, and each result is
// compared with it field by field. The smoothing weight is swept across its
// range, and sender gaps and receiver stalls vary from phase to phase.
// ----------------------------------------------------------------------------
module strand_smoothing_filter_test;
	timeunit 1ns;
	timeprecision 1ps;
	import ssf_pkg::*;

	localparam int CW          = 32;
	localparam int TDATA_W     = ((3 * CW + 7) / 8) * 8;
	localparam int N_DIRECTED  = 23;
	localparam int N_PHASES    = 8;
	localparam int PHASE_BEATS = 191;

	localparam longint COORD_MAX = 64'sh7FFF_FFFF;
	localparam longint COORD_MIN = -COORD_MAX - 1;

	// one result beat: x in the lowest lane, as on m_tdata
	typedef struct packed {
		logic                sat;
		logic [2:0][CW-1:0]  vec;
	} smooth_beat_t;

	// directed row: stimulus, plus a typed-in result where it is obvious
	typedef struct {
		logic          start;
		logic [31:0]   x, y, z;
		logic          typed;
		logic [31:0]   ex, ey, ez;
		logic          esat;
	} stim_row_t;

	stim_row_t directed_rows [N_DIRECTED] = '{
		// no strand start since reset: treated as a first point
		'{1'b0, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
			1'b1, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 1'b0},
		// second point with a difference that clips low on y
		'{1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0005,
			1'b0, '0, '0, '0, 1'b0},
		'{1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
			1'b0, '0, '0, '0, 1'b0},
		// first point at the extremes passes through unflagged
		'{1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
			1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 1'b0},
		// full-swing differences both ways clip, sums land on -1
		'{1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
			1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1},
		'{1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			1'b0, '0, '0, '0, 1'b0},
		'{1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			1'b0, '0, '0, '0, 1'b0},
		'{1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
			1'b0, '0, '0, '0, 1'b0},
		// a strand at rest stays put
		'{1'b1, 32'h0064_0000, 32'h0064_0000, 32'h0064_0000,
			1'b1, 32'h0064_0000, 32'h0064_0000, 32'h0064_0000, 1'b0},
		'{1'b0, 32'h0064_0000, 32'h0064_0000, 32'h0064_0000,
			1'b1, 32'h0064_0000, 32'h0064_0000, 32'h0064_0000, 1'b0},
		'{1'b0, 32'h0064_0000, 32'h0064_0000, 32'h0064_0000,
			1'b1, 32'h0064_0000, 32'h0064_0000, 32'h0064_0000, 1'b0},
		'{1'b0, 32'h0064_0000, 32'h0064_0000, 32'h0064_0000,
			1'b1, 32'h0064_0000, 32'h0064_0000, 32'h0064_0000, 1'b0},
		// back-to-back single-point strands
		'{1'b1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
			1'b1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0},
		'{1'b1, 32'hFFFF_0000, 32'h0001_0000, 32'h8000_0000,
			1'b1, 32'hFFFF_0000, 32'h0001_0000, 32'h8000_0000, 1'b0},
		// steady half-unit ramp
		'{1'b0, 32'hFFFF_8000, 32'h0001_8000, 32'h8000_8000,
			1'b0, '0, '0, '0, 1'b0},
		'{1'b0, 32'h0000_0000, 32'h0002_0000, 32'h8001_0000,
			1'b0, '0, '0, '0, 1'b0},
		'{1'b0, 32'h0000_8000, 32'h0002_8000, 32'h8001_8000,
			1'b0, '0, '0, '0, 1'b0},
		'{1'b0, 32'h0001_0000, 32'h0003_0000, 32'h8002_0000,
			1'b0, '0, '0, '0, 1'b0},
		// ramp into the rails: the running sum clips
		'{1'b1, 32'h7FFF_0000, 32'h7FFF_0000, 32'h8001_0000,
			1'b1, 32'h7FFF_0000, 32'h7FFF_0000, 32'h8001_0000, 1'b0},
		'{1'b0, 32'h7FFF_8000, 32'h7FFF_8000, 32'h8000_8000,
			1'b0, '0, '0, '0, 1'b0},
		'{1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			1'b0, '0, '0, '0, 1'b0},
		'{1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			1'b0, '0, '0, '0, 1'b0},
		'{1'b0, 32'h0000_0000, 32'h1234_5678, 32'h8765_4321,
			1'b0, '0, '0, '0, 1'b0}
	};

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [BETA_W-1:0]  cfg_data;      // beta_q16
	logic               s_tvalid;
	logic               s_tready;
	logic [TDATA_W-1:0] s_tdata;       // vec_x, vec_y, vec_z
	logic [0:0]         s_tuser;       // strand_start
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;       // smooth_x, smooth_y, smooth_z
	logic [0:0]         m_tuser;       // saturated

	// idling knobs, percent of cycles
	int gap_pct   = 0;
	int stall_pct = 0;

	// smoother model state
	logic [BETA_W-1:0] beta_model = BETA_ONE >> 1;
	longint            last_pt [3]     = '{0, 0, 0};
	longint            diff_1 [3]      = '{0, 0, 0};   // d(i-1)
	longint            diff_2 [3]      = '{0, 0, 0};   // d(i-2)
	longint            last_smooth [3] = '{0, 0, 0};
	int                pt_count        = 0;            // saturates at 2

	smooth_beat_t pending_smooth [$];

	int    mismatch_count  = 0;
	int    vectors_sent    = 0;
	int    strands_seen    = 0;
	int    clipped_results = 0;
	int    betas_used      = 1;
	string lane_name [3]   = '{"smooth_x", "smooth_y", "smooth_z"};

	strand_smoothing_filter #(
		.COORD_WIDTH(CW)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: random backpressure at the rate of the current phase
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// clip to the signed coordinate range, noting any clip
	function automatic longint clip_coord(input longint r, inout logic hit);
		if (r > COORD_MAX) begin
			hit = 1'b1;
			return COORD_MAX;
		end
		if (r < COORD_MIN) begin
			hit = 1'b1;
			return COORD_MIN;
		end
		return r;
	endfunction

	// advance the smoother model by one accepted vector
	task automatic smooth_step(input logic start, input logic [2:0][CW-1:0] pt,
			output smooth_beat_t res);
		longint    b, m, k1, k2, k3, p, delta, d, s;
		logic      hit;
		ssf_mode_t mode;
		// weights above 1.0 act as 1.0; coefficients are Q.16
		b  = (beta_model > BETA_ONE) ? longint'(BETA_ONE) : longint'(beta_model);
		m  = longint'(BETA_ONE) - b;
		k1 = 2 * m;
		k2 = (m * m + longint'(BETA_ROUND)) >>> BETA_FRAC;
		k3 = (b * b + longint'(BETA_ROUND)) >>> BETA_FRAC;
		hit = 1'b0;
		if (start || pt_count == 0)
			mode = MODE_FIRST;
		else if (pt_count == 1)
			mode = MODE_SECOND;
		else
			mode = MODE_STEADY;
		for (int j = 0; j < 3; j++) begin
			p = longint'($signed(pt[j]));
			case (mode)
				MODE_FIRST: begin
					s = p;
					diff_1[j] = 0;
					diff_2[j] = 0;
				end
				MODE_SECOND: begin
					// raw difference seeds both taps
					d = clip_coord(p - last_pt[j], hit);
					s = clip_coord(last_smooth[j] + d, hit);
					diff_1[j] = d;
					diff_2[j] = d;
				end
				default: begin
					delta = clip_coord(p - last_pt[j], hit);
					// exact accumulate, round half up, floor shift
					d = clip_coord((k1 * diff_1[j] - k2 * diff_2[j] + k3 * delta
						+ longint'(BETA_ROUND)) >>> BETA_FRAC, hit);
					s = clip_coord(last_smooth[j] + d, hit);
					diff_2[j] = diff_1[j];
					diff_1[j] = d;
				end
			endcase
			last_pt[j]     = p;
			last_smooth[j] = s;
			res.vec[j]     = s[CW-1:0];
		end
		res.sat = hit;
		if (mode == MODE_FIRST) begin
			pt_count = 1;
			strands_seen++;
		end else begin
			pt_count = 2;
		end
	endtask

	// one input beat, with a random gap ahead of it; valid stays up after the
	// handshake so the next beat can follow without a bubble
	task automatic send_vec(input logic start, input logic [2:0][CW-1:0] pt,
			input logic typed, input smooth_beat_t typed_res);
		smooth_beat_t res;
		while ($urandom_range(0, 99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= pt;
		s_tuser  <= start;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		smooth_step(start, pt, res);
		pending_smooth.insert(pending_smooth.size(), typed ? typed_res : res);
		vectors_sent++;
	endtask

	// hold the sender off until every smoothed vector is back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_smooth.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_beta(input logic [BETA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid  <= 1'b0;
		beta_model = value;
		betas_used++;
	endtask

	// random strands: mostly random walks of varied step size, plus strands
	// hugging the rails, white noise, stray starts and missing starts
	task automatic run_strands(input int n_beats);
		int                 left, len, style, sh, step;
		logic [2:0][CW-1:0] walk;
		logic               start;
		left = n_beats;
		while (left > 0) begin
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 60)
				: $urandom_range(1, 24);
			if (len > left)
				len = left;
			style = $urandom_range(0, 9);
			sh    = $urandom_range(4, 28);
			for (int j = 0; j < 3; j++)
				walk[j] = $urandom;
			for (int k = 0; k < len; k++) begin
				for (int j = 0; j < 3; j++) begin
					if (style <= 5) begin
						step    = $signed($urandom) >>> sh;
						walk[j] = walk[j] + step;
					end else if (style <= 7) begin
						walk[j] = $urandom_range(0, 1)
							? 32'h7FFF_FFFF - $urandom_range(0, 65535)
							: 32'h8000_0000 + $urandom_range(0, 65535);
					end else begin
						walk[j] = $urandom;
					end
				end
				// first beat sometimes lacks the start flag: it then
				// continues the previous strand
				start = (k == 0) ? ($urandom_range(0, 9) != 0)
					: ($urandom_range(0, 39) == 0);
				send_vec(start, walk, 1'b0, '0);
			end
			left -= len;
		end
	endtask

	// result checker: every output beat against the oldest prediction
	always @(posedge clk) begin : result_check
		smooth_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_smooth.size() == 0) begin
				mismatch_count++;
				$display("%0t: result beat with nothing expected, actual %h sat %b",
					$time, m_tdata, m_tuser);
			end else begin
				want = pending_smooth.pop_front();
				for (int j = 0; j < 3; j++) begin
					if (m_tdata[j*CW +: CW] !== want.vec[j]) begin
						mismatch_count++;
						$display("%0t: %s expected %h actual %h", $time,
							lane_name[j], want.vec[j], m_tdata[j*CW +: CW]);
					end
				end
				if (m_tuser[0] !== want.sat) begin
					mismatch_count++;
					$display("%0t: saturated expected %b actual %b", $time,
						want.sat, m_tuser[0]);
				end
				if (want.sat)
					clipped_results++;
			end
		end
	end

	initial begin : stimulus
		logic [BETA_W-1:0]  beta_plan [N_PHASES];
		logic [2:0][CW-1:0] pt;
		smooth_beat_t       want;
		arst_n    <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= '0;
		// zero, one, above one (all ones), tiny, just under one, just over one, randoms
		beta_plan = '{17'd0, BETA_ONE, 17'h1FFFF, 17'd1, 17'd65535,
			17'd0, BETA_ONE + 17'd1, 17'd0};
		beta_plan[5] = BETA_W'($urandom_range(0, 131071));
		beta_plan[7] = BETA_W'($urandom_range(0, 65536));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed rows run at the reset weight, no idling
		foreach (directed_rows[i]) begin
			pt       = {directed_rows[i].z, directed_rows[i].y, directed_rows[i].x};
			want.vec = {directed_rows[i].ez, directed_rows[i].ey, directed_rows[i].ex};
			want.sat = directed_rows[i].esat;
			send_vec(directed_rows[i].start, pt, directed_rows[i].typed, want);
		end
		drain_results();

		// weight sweep; idling pattern rotates: none, sender gaps,
		// receiver stalls, light on both sides
		for (int ph = 0; ph < N_PHASES; ph++) begin
			case (ph % 4)
				0: begin
					gap_pct   = 0;
					stall_pct = 0;
				end
				1: begin
					gap_pct   = 75;
					stall_pct = 0;
				end
				2: begin
					gap_pct   = 0;
					stall_pct = 75;
				end
				default: begin
					gap_pct   = 12;
					stall_pct = 12;
				end
			endcase
			write_beta(beta_plan[ph]);
			run_strands(PHASE_BEATS / 2);
			// mid-phase pause: pipeline runs dry with history kept
			drain_results();
			run_strands(PHASE_BEATS - PHASE_BEATS / 2);
			drain_results();
		end

		// room for any stray beat to show up
		repeat (8) @(posedge clk);
		$display("Smoothed %0d vectors over %0d strands at %0d weight settings,",
			vectors_sent, strands_seen, betas_used);
		$display("with gaps and stalls on both sides; %0d results came back clipped.",
			clipped_results);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin : watchdog
		#2_000_000;
		$display("%0t: timeout, %0d results still pending", $time, pending_smooth.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- strand_smoothing_filter.f -----
hdl/ssf_pkg.sv
hdl/ssf_lane.sv
hdl/strand_smoothing_filter.sv
hdl/ssf_checker.sv
tb/strand_smoothing_filter_test.sv
